@@ sv/pbme_pkg.sv @@
package pbme_pkg;

  // Pipeline depth of one color lane, from the input register to the output register.
  localparam int unsigned NUM_STAGES = 7;

  localparam logic [8:0] WEIGHT_ONE = 9'd256;

  localparam logic [4:0] MODE_NORMAL      = 5'd0;
  localparam logic [4:0] MODE_LIGHTEN     = 5'd1;
  localparam logic [4:0] MODE_DARKEN      = 5'd2;
  localparam logic [4:0] MODE_MULTIPLY    = 5'd3;
  localparam logic [4:0] MODE_AVERAGE     = 5'd4;
  localparam logic [4:0] MODE_ADD         = 5'd5;
  localparam logic [4:0] MODE_SUBTRACT    = 5'd6;
  localparam logic [4:0] MODE_DIFFERENCE  = 5'd7;
  localparam logic [4:0] MODE_NEGATION    = 5'd8;
  localparam logic [4:0] MODE_SCREEN      = 5'd9;
  localparam logic [4:0] MODE_EXCLUSION   = 5'd10;
  localparam logic [4:0] MODE_OVERLAY     = 5'd11;
  localparam logic [4:0] MODE_SOFT_LIGHT  = 5'd12;
  localparam logic [4:0] MODE_HARD_LIGHT  = 5'd13;
  localparam logic [4:0] MODE_COLOR_DODGE = 5'd14;
  localparam logic [4:0] MODE_COLOR_BURN  = 5'd15;
  localparam logic [4:0] MODE_LIN_DODGE   = 5'd16;
  localparam logic [4:0] MODE_LIN_BURN    = 5'd17;
  localparam logic [4:0] MODE_LIN_LIGHT   = 5'd18;
  localparam logic [4:0] MODE_VIVID_LIGHT = 5'd19;
  localparam logic [4:0] MODE_PIN_LIGHT   = 5'd20;
  localparam logic [4:0] MODE_HARD_MIX    = 5'd21;
  localparam logic [4:0] MODE_REFLECT     = 5'd22;
  localparam logic [4:0] MODE_GLOW        = 5'd23;
  localparam logic [4:0] MODE_PHOENIX     = 5'd24;
  localparam logic [4:0] MODE_DIVIDE      = 5'd25;

  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_MIX_WEIGHT = 1'b1;

  // Per-channel operands that ride along the divider stages.
  typedef struct packed {
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] d;    // derived mask for the linear, vivid and pin light modes
    logic       lo;   // mask below half
    logic [8:0] aux;  // product result scaled by 1/255 or 1/256
  } ctx_t;

  // Floor of x/255 for x below 255 * 2^9 = 130560, using 256q + r = 255q + (q + r).
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [8:0] q;
    logic [9:0] r;
    q = x[16:8];
    r = {2'b00, x[7:0]} + {1'b0, q};
    if (r >= 10'd255) begin
      r = r - 10'd255;
      q = q + 9'd1;
    end
    if (r >= 10'd255) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

endpackage

@@ sv/pbme_div.sv @@
// Pipelined restoring divider, three quotient bits per stage. The quotient
// saturates to all ones when it would not fit in nine bits.
module pbme_div (
  input  logic              clk_i,
  input  logic [2:0]        en_i,
  input  logic [15:0]       num_i,
  input  logic [7:0]        den_i,
  input  pbme_pkg::ctx_t    ctx_i,
  output logic [8:0]        quo_o,
  output pbme_pkg::ctx_t    ctx_o
);

  logic [8:0]     rem_q [3];
  logic [8:0]     quo_q [3];
  logic [15:0]    num_q [3];
  logic [7:0]     den_q [3];
  logic           ovf_q [3];
  pbme_pkg::ctx_t ctx_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_stage
    logic [8:0]     rem_in;
    logic [8:0]     quo_in;
    logic [15:0]    num_in;
    logic [7:0]     den_in;
    logic           ovf_in;
    pbme_pkg::ctx_t ctx_in;
    logic [8:0]     rem_d;
    logic [8:0]     quo_d;

    if (k == 0) begin : g_first
      assign rem_in = {2'b00, num_i[15:9]};
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign ovf_in = ({1'b0, num_i[15:9]} >= den_i);
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < 3; j++) begin
        rem_d = {rem_d[7:0], num_in[8 - 3*k - j]};
        if (rem_d >= {1'b0, den_in}) begin
          rem_d = rem_d - {1'b0, den_in};
          quo_d[8 - 3*k - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        ovf_q[k] <= ovf_in;
        ctx_q[k] <= ctx_in;
      end
    end
  end

  assign quo_o = ovf_q[2] ? 9'h1FF : quo_q[2];
  assign ctx_o = ctx_q[2];

endmodule

@@ sv/pbme_lane.sv @@
// One color channel: operand select and multiply, scaling, division,
// blend function and final weighted mix.
module pbme_lane (
  input  logic                              clk_i,
  input  logic [pbme_pkg::NUM_STAGES-1:0]   en_i,
  input  logic [4:0]                        mode_i,
  input  logic [8:0]                        weight_i,
  input  logic [7:0]                        s_i,
  input  logic [7:0]                        m_i,
  output logic [7:0]                        res_o
);

  // Stage 1: operands and product.
  logic [8:0]  mul_a;
  logic [7:0]  mul_b;
  logic [7:0]  half_m;
  logic [16:0] prod_q;
  logic [7:0]  s1_q, m1_q;

  always_comb begin
    half_m = {1'b0, m_i[7:1]};
    mul_a  = '0;
    mul_b  = '0;
    unique case (mode_i)
      pbme_pkg::MODE_MULTIPLY, pbme_pkg::MODE_EXCLUSION: begin
        mul_a = {1'b0, s_i};
        mul_b = m_i;
      end
      pbme_pkg::MODE_SCREEN: begin
        mul_a = {1'b0, ~s_i};
        mul_b = ~m_i;
      end
      pbme_pkg::MODE_OVERLAY: begin
        mul_a = m_i[7] ? {1'b0, ~s_i} : {1'b0, s_i};
        mul_b = m_i[7] ? ~m_i : m_i;
      end
      pbme_pkg::MODE_HARD_LIGHT: begin
        mul_a = s_i[7] ? {1'b0, ~s_i} : {1'b0, s_i};
        mul_b = s_i[7] ? ~m_i : m_i;
      end
      pbme_pkg::MODE_SOFT_LIGHT: begin
        if (!s_i[7]) begin
          mul_a = {half_m + 8'd64, 1'b0};
          mul_b = s_i;
        end else begin
          mul_a = {8'd191 - half_m, 1'b0};
          mul_b = ~s_i;
        end
      end
      pbme_pkg::MODE_REFLECT: begin
        mul_a = {1'b0, s_i};
        mul_b = s_i;
      end
      pbme_pkg::MODE_GLOW: begin
        mul_a = {1'b0, m_i};
        mul_b = m_i;
      end
      pbme_pkg::MODE_DIVIDE: begin
        mul_a = 9'd255;
        mul_b = s_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= 17'(mul_a * mul_b);
      s1_q   <= s_i;
      m1_q   <= m_i;
    end
  end

  // Stage 2: scaling by 1/255 or 1/256 and divider operand select.
  logic [16:0]    scale_in;
  pbme_pkg::ctx_t ctx2_d, ctx2_q;
  logic [15:0]    num_d, num_q;
  logic [7:0]     den_d, den_q;

  always_comb begin
    ctx2_d.s  = s1_q;
    ctx2_d.m  = m1_q;
    ctx2_d.d  = {m1_q[6:0], 1'b0};
    ctx2_d.lo = ~m1_q[7];
    scale_in  = prod_q;
    num_d     = prod_q[15:0];
    den_d     = '0;
    unique case (mode_i)
      pbme_pkg::MODE_EXCLUSION, pbme_pkg::MODE_OVERLAY, pbme_pkg::MODE_HARD_LIGHT: begin
        scale_in = {prod_q[15:0], 1'b0};
      end
      pbme_pkg::MODE_SOFT_LIGHT: begin
        scale_in = s1_q[7] ? prod_q + 17'd254 : prod_q;
      end
      pbme_pkg::MODE_COLOR_DODGE: begin
        num_d = {s1_q, 8'd0};
        den_d = ~m1_q;
      end
      pbme_pkg::MODE_COLOR_BURN: begin
        num_d = {~s1_q, 8'd0};
        den_d = m1_q;
      end
      pbme_pkg::MODE_VIVID_LIGHT, pbme_pkg::MODE_HARD_MIX: begin
        num_d = m1_q[7] ? {s1_q, 8'd0} : {~s1_q, 8'd0};
        den_d = m1_q[7] ? ~ctx2_d.d : ctx2_d.d;
      end
      pbme_pkg::MODE_REFLECT: begin
        den_d = ~m1_q;
      end
      pbme_pkg::MODE_GLOW: begin
        den_d = ~s1_q;
      end
      pbme_pkg::MODE_DIVIDE: begin
        den_d = m1_q;
      end
      default: begin
        scale_in = prod_q;
      end
    endcase
    // Screen scales by 1/256, everything else by 1/255.
    ctx2_d.aux = (mode_i == pbme_pkg::MODE_SCREEN) ? prod_q[16:8]
                                                    : pbme_pkg::div255(scale_in);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctx2_q <= ctx2_d;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  // Stages 3 to 5: division.
  logic [8:0]     quo;
  pbme_pkg::ctx_t ctx5;

  pbme_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i[4:2]),
    .num_i (num_q),
    .den_i (den_q),
    .ctx_i (ctx2_q),
    .quo_o (quo),
    .ctx_o (ctx5)
  );

  // Stage 6: blend function.
  logic [7:0] s6, m6, d6;
  logic [7:0] quo_sat;
  logic [8:0] sum_sm;
  logic [8:0] sum_sd;
  logic [7:0] diff_sm;
  logic [9:0] excl;
  logic [7:0] blend_d, partner_d;
  logic       bypass_d;
  logic [7:0] blend_q, partner_q, src_q;
  logic       bypass_q;

  always_comb begin
    s6       = ctx5.s;
    m6       = ctx5.m;
    d6       = ctx5.d;
    quo_sat  = (quo > 9'd255) ? 8'd255 : quo[7:0];
    sum_sm   = {1'b0, s6} + {1'b0, m6};
    sum_sd   = {1'b0, s6} + {1'b0, d6};
    diff_sm  = (s6 > m6) ? s6 - m6 : m6 - s6;
    excl     = {1'b0, sum_sm} - {1'b0, ctx5.aux};
    blend_d  = '0;
    partner_d = m6;
    bypass_d = 1'b0;
    unique case (mode_i)
      pbme_pkg::MODE_NORMAL: begin
        bypass_d  = (m6 == 8'd0);
        partner_d = s6;
        blend_d   = m6;
      end
      pbme_pkg::MODE_LIGHTEN:    blend_d = (s6 > m6) ? s6 : m6;
      pbme_pkg::MODE_DARKEN:     blend_d = (s6 < m6) ? s6 : m6;
      pbme_pkg::MODE_MULTIPLY:   blend_d = ctx5.aux[7:0];
      pbme_pkg::MODE_AVERAGE:    blend_d = sum_sm[8:1];
      pbme_pkg::MODE_ADD, pbme_pkg::MODE_LIN_DODGE: begin
        blend_d = sum_sm[8] ? 8'd255 : sum_sm[7:0];
      end
      pbme_pkg::MODE_SUBTRACT, pbme_pkg::MODE_LIN_BURN: begin
        blend_d = (sum_sm < 9'd255) ? 8'd0 : 8'(sum_sm - 9'd255);
      end
      pbme_pkg::MODE_DIFFERENCE: blend_d = diff_sm;
      pbme_pkg::MODE_NEGATION: begin
        blend_d = (sum_sm > 9'd255) ? 8'(9'd510 - sum_sm) : sum_sm[7:0];
      end
      pbme_pkg::MODE_SCREEN:     blend_d = ~ctx5.aux[7:0];
      pbme_pkg::MODE_EXCLUSION:  blend_d = (excl > 10'd255) ? 8'd255 : excl[7:0];
      pbme_pkg::MODE_OVERLAY:    blend_d = m6[7] ? ~ctx5.aux[7:0] : ctx5.aux[7:0];
      pbme_pkg::MODE_SOFT_LIGHT: begin
        if (!s6[7]) begin
          blend_d = ctx5.aux[7:0];
        end else begin
          blend_d = (ctx5.aux >= 9'd255) ? 8'd0 : ~ctx5.aux[7:0];
        end
      end
      pbme_pkg::MODE_HARD_LIGHT: begin
        partner_d = s6;
        blend_d   = s6[7] ? ~ctx5.aux[7:0] : ctx5.aux[7:0];
      end
      pbme_pkg::MODE_COLOR_DODGE, pbme_pkg::MODE_REFLECT: begin
        blend_d = (m6 == 8'd255) ? m6 : quo_sat;
      end
      pbme_pkg::MODE_COLOR_BURN: begin
        blend_d = (m6 == 8'd0 || quo >= 9'd255) ? 8'd0 : ~quo[7:0];
      end
      pbme_pkg::MODE_LIN_LIGHT: begin
        partner_d = d6;
        if (ctx5.lo) begin
          blend_d = (sum_sd < 9'd255) ? 8'd0 : 8'(sum_sd - 9'd255);
        end else begin
          blend_d = sum_sd[8] ? 8'd255 : sum_sd[7:0];
        end
      end
      pbme_pkg::MODE_VIVID_LIGHT, pbme_pkg::MODE_HARD_MIX: begin
        partner_d = d6;
        if (ctx5.lo) begin
          blend_d = (d6 == 8'd0 || quo >= 9'd255) ? 8'd0 : ~quo[7:0];
        end else begin
          blend_d = quo_sat;
        end
      end
      pbme_pkg::MODE_PIN_LIGHT: begin
        partner_d = d6;
        if (ctx5.lo) begin
          blend_d = (s6 < d6) ? s6 : d6;
        end else begin
          blend_d = (s6 > d6) ? s6 : d6;
        end
      end
      pbme_pkg::MODE_GLOW: begin
        partner_d = s6;
        blend_d   = (s6 == 8'd255) ? s6 : quo_sat;
      end
      pbme_pkg::MODE_PHOENIX:    blend_d = ~diff_sm;
      pbme_pkg::MODE_DIVIDE:     blend_d = (m6 == 8'd0) ? 8'd255 : quo_sat;
      default:                   bypass_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      blend_q   <= blend_d;
      partner_q <= partner_d;
      bypass_q  <= bypass_d;
      src_q     <= s6;
    end
  end

  // Stage 7: mix as 256*B + w*(P - B), then shift by eight; bypass passes the source and hard mix thresholds.
  logic signed [9:0]  wt_s;
  logic signed [9:0]  diff_s;
  logic signed [19:0] term;
  logic signed [19:0] mix_sum;
  logic [7:0]         mixed;
  logic [7:0]         res_d, res_q;

  always_comb begin
    wt_s    = $signed({1'b0, weight_i});
    diff_s  = $signed({2'b00, partner_q}) - $signed({2'b00, blend_q});
    term    = wt_s * diff_s;
    mix_sum = $signed({4'b0000, blend_q, 8'd0}) + term;
    mixed   = mix_sum[15:8];
    if (bypass_q) begin
      res_d = src_q;
    end else if (mode_i == pbme_pkg::MODE_HARD_MIX) begin
      res_d = mixed[7] ? 8'd255 : 8'd0;
    end else begin
      res_d = mixed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/pixel_blend_mode_engine.sv @@
// Throughput: one pixel per cycle while the output stream accepts results; three channel
// lanes run in parallel and the divider in each lane is pipelined at three quotient
// bits per stage.
// Reset: rst_ni clears all pipeline valid bits, sets blend_mode to normal and
// mix_weight to 256 (full weight); no clearing pass is needed.
module pixel_blend_mode_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] src_pixel, [63:32] mask_pixel
  input  logic        s_axis_tlast_i,   // end_of_frame
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_pixel
  output logic        m_axis_tlast_o    // end_of_frame_res
);

  localparam int unsigned NS = pbme_pkg::NUM_STAGES;

  // Configuration registers. Writes must come only while the pipeline is empty; the block does not enforce it.
  logic [4:0] mode_q;
  logic [8:0] weight_q;
  logic [8:0] weight_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pbme_pkg::MODE_NORMAL;
      weight_q <= pbme_pkg::WEIGHT_ONE;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pbme_pkg::REG_BLEND_MODE) begin
        mode_q <= cfg_data_i[4:0];
      end else begin
        weight_q <= cfg_data_i;
      end
    end
  end

  // A weight above one acts as one.
  assign weight_eff = (weight_q > pbme_pkg::WEIGHT_ONE) ? pbme_pkg::WEIGHT_ONE : weight_q;

  // Pipeline control. Each stage advances when it is empty or when the stage
  // after it advances, so bubbles collapse and the input keeps flowing while
  // a finished item waits at the output, as long as an empty stage remains ahead.
  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;
  logic [NS-1:0] last_q;

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // The frame marker travels beside the lanes.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= s_axis_tlast_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // Three channel lanes: red, green and blue.
  logic [7:0] chan_res [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pbme_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .mode_i   (mode_q),
      .weight_i (weight_eff),
      .s_i      (s_axis_tdata_i[8*c +: 8]),
      .m_i      (s_axis_tdata_i[32 + 8*c +: 8]),
      .res_o    (chan_res[c])
    );
  end

  // Merge: opaque alpha over the three blended channels.
  assign m_axis_tdata_o  = {8'hFF, chan_res[2], chan_res[1], chan_res[0]};
  assign m_axis_tvalid_o = valid_q[NS-1];
  assign m_axis_tlast_o  = last_q[NS-1];
  assign s_axis_tready_o = en[0];

endmodule
